@@ hdl/rqsi_pkg.sv @@
// rqsi_pkg: shared types, constants and helper functions for the ring queue
// with sorted insert; used by rqsi_ctrl, rqsi_dpath and the top level
// no dependencies
`default_nettype none

package rqsi_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(QUEUE_SLOTS);
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 4;

    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [WORD_W-1:0]     word_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef enum logic [1:0] {
        REQ_STATUS = 2'd0,
        REQ_ENQ    = 2'd1,
        REQ_PRIO   = 2'd2,
        REQ_DEQ    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_PLACE,
        ST_DEQ,
        ST_STAT_H,
        ST_STAT_T,
        ST_STAT_D,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic refuse;
        logic push;
        logic walk_start;
        logic walk_shift;
        logic place;
        logic deq_read;
        logic deq_take;
        logic rd_head;
        logic cap_head;
        logic cap_tail;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic greater;
        logic walk_last;
    } sts_t;

    function automatic idx_t wrap_inc(input idx_t i);
        return (i == idx_t'(QUEUE_SLOTS - 1)) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? idx_t'(QUEUE_SLOTS - 1) : idx_t'(i - idx_t'(1));
    endfunction

    function automatic idx_t count_of(input idx_t head, input idx_t tail);
        logic [IDX_W:0] sum;
        sum = {1'b0, tail} + (IDX_W+1)'(QUEUE_SLOTS) - {1'b0, head};
        if (tail >= head)
            return idx_t'(tail - head);
        else
            return sum[IDX_W-1:0];
    endfunction

    function automatic data_t to_data(input word_t w);
        return data_t'(w);
    endfunction

    function automatic word_t to_word(input data_t d);
        return word_t'(d);
    endfunction

endpackage

`default_nettype wire

@@ hdl/rqsi_dpath.sv @@
// rqsi_dpath: pointers, slot memory, walk index and result registers
// depends on rqsi_pkg; driven by commands from rqsi_ctrl
`default_nettype none

module rqsi_dpath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [1:0]            req_type,
    input  wire [31:0]           value,
    input  rqsi_pkg::cmd_t       cmd,
    output rqsi_pkg::sts_t       sts,
    output logic                 accepted,
    output logic [31:0]          out_value,
    output logic [31:0]          head_value,
    output logic [31:0]          tail_value,
    output logic [3:0]           occupancy,
    output logic                 is_empty,
    output logic                 is_full,
    output logic [3:0]           free_slots
);

    rqsi_pkg::data_t mem [rqsi_pkg::QUEUE_SLOTS];

    rqsi_pkg::idx_t  head_reg, tail_reg, idx_reg, cnt_reg;
    rqsi_pkg::req_t  req_reg;
    rqsi_pkg::data_t value_reg, rdata_reg;
    rqsi_pkg::word_t deq_reg, headv_reg, tailv_reg;
    logic            acc_reg;

    logic            acc_out_reg, empty_out_reg, full_out_reg;
    rqsi_pkg::word_t deq_out_reg, headv_out_reg, tailv_out_reg;
    rqsi_pkg::cnt_t  occ_out_reg, free_out_reg;

    rqsi_pkg::idx_t  occ;
    logic            empty, full;
    logic            wr_en, rd_en;
    rqsi_pkg::idx_t  wr_addr, rd_addr;
    rqsi_pkg::data_t wr_data;
    logic [rqsi_pkg::IDX_W:0] cnt_inc;

    assign occ     = rqsi_pkg::count_of(head_reg, tail_reg);
    assign empty   = (head_reg == tail_reg);
    assign full    = (rqsi_pkg::wrap_inc(tail_reg) == head_reg);
    assign cnt_inc = {1'b0, cnt_reg} + (rqsi_pkg::IDX_W+1)'(1);

    always_comb
    begin
        sts.req       = req_reg;
        sts.full      = full;
        sts.empty     = empty;
        sts.greater   = (rdata_reg > value_reg);
        sts.walk_last = (cnt_inc == {1'b0, occ});
    end

    // one write and one read port on the slot memory
    always_comb
    begin
        wr_en   = cmd.push | cmd.walk_shift | cmd.place;
        wr_addr = cmd.push ? tail_reg : rqsi_pkg::wrap_inc(idx_reg);
        wr_data = cmd.walk_shift ? rdata_reg : value_reg;
        rd_en   = cmd.walk_start | cmd.walk_shift | cmd.deq_read | cmd.rd_head | cmd.cap_head;
        if (cmd.walk_shift)
            rd_addr = rqsi_pkg::wrap_dec(idx_reg);
        else if (cmd.walk_start || cmd.cap_head)
            rd_addr = rqsi_pkg::wrap_dec(tail_reg);
        else
            rd_addr = head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (cmd.push || cmd.place)
                tail_reg <= rqsi_pkg::wrap_inc(tail_reg);
            if (cmd.deq_take)
                head_reg <= rqsi_pkg::wrap_inc(head_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= rqsi_pkg::req_t'(req_type);
            value_reg <= rqsi_pkg::to_data(rqsi_pkg::word_t'(value));
        end
        if (cmd.exec)
        begin
            acc_reg <= ~cmd.refuse;
            deq_reg <= '0;
        end
        if (cmd.walk_start)
        begin
            idx_reg <= rqsi_pkg::wrap_dec(tail_reg);
            cnt_reg <= '0;
        end
        if (cmd.walk_shift)
        begin
            idx_reg <= rqsi_pkg::wrap_dec(idx_reg);
            cnt_reg <= cnt_inc[rqsi_pkg::IDX_W-1:0];
        end
        if (cmd.deq_take)
            deq_reg <= rqsi_pkg::to_word(rdata_reg);
        if (cmd.cap_head)
            headv_reg <= rqsi_pkg::to_word(rdata_reg);
        if (cmd.cap_tail)
            tailv_reg <= rqsi_pkg::to_word(rdata_reg);
        if (cmd.out_load)
        begin
            acc_out_reg   <= acc_reg;
            deq_out_reg   <= deq_reg;
            headv_out_reg <= empty ? '0 : headv_reg;
            tailv_out_reg <= empty ? '0 : tailv_reg;
            occ_out_reg   <= rqsi_pkg::cnt_t'(occ);
            empty_out_reg <= empty;
            full_out_reg  <= full;
            free_out_reg  <= rqsi_pkg::cnt_t'(
                rqsi_pkg::idx_t'(rqsi_pkg::QUEUE_SLOTS - 1) - occ);
        end
    end

    assign accepted   = acc_out_reg;
    assign out_value  = deq_out_reg;
    assign head_value = headv_out_reg;
    assign tail_value = tailv_out_reg;
    assign occupancy  = occ_out_reg;
    assign is_empty   = empty_out_reg;
    assign is_full    = full_out_reg;
    assign free_slots = free_out_reg;

endmodule

`default_nettype wire

@@ hdl/rqsi_ctrl.sv @@
// rqsi_ctrl: request sequencer for the ring queue with sorted insert
// depends on rqsi_pkg; issues commands to rqsi_dpath and owns both handshakes
`default_nettype none

module rqsi_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  rqsi_pkg::sts_t       sts,
    output rqsi_pkg::cmd_t       cmd
);

    rqsi_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rqsi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            rqsi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rqsi_pkg::ST_EXEC;
                end
            end
            rqsi_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = rqsi_pkg::ST_STAT_H;
                case (sts.req)
                    rqsi_pkg::REQ_ENQ:
                    begin
                        if (sts.full)
                            cmd.refuse = 1'b1;
                        else
                            cmd.push = 1'b1;
                    end
                    rqsi_pkg::REQ_PRIO:
                    begin
                        if (sts.full)
                            cmd.refuse = 1'b1;
                        else if (sts.empty)
                            cmd.push = 1'b1;
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = rqsi_pkg::ST_WALK;
                        end
                    end
                    rqsi_pkg::REQ_DEQ:
                    begin
                        if (sts.empty)
                            cmd.refuse = 1'b1;
                        else
                        begin
                            cmd.deq_read = 1'b1;
                            state_next   = rqsi_pkg::ST_DEQ;
                        end
                    end
                    default:
                    begin
                        cmd.refuse = 1'b0;
                    end
                endcase
            end
            rqsi_pkg::ST_WALK:
            begin
                // shift the larger entry up and fetch the one below it
                if (sts.greater)
                begin
                    cmd.walk_shift = 1'b1;
                    if (sts.walk_last)
                        state_next = rqsi_pkg::ST_PLACE;
                end
                else
                    state_next = rqsi_pkg::ST_PLACE;
            end
            rqsi_pkg::ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = rqsi_pkg::ST_STAT_H;
            end
            rqsi_pkg::ST_DEQ:
            begin
                cmd.deq_take = 1'b1;
                state_next   = rqsi_pkg::ST_STAT_H;
            end
            rqsi_pkg::ST_STAT_H:
            begin
                cmd.rd_head = 1'b1;
                state_next  = rqsi_pkg::ST_STAT_T;
            end
            rqsi_pkg::ST_STAT_T:
            begin
                cmd.cap_head = 1'b1;
                state_next   = rqsi_pkg::ST_STAT_D;
            end
            rqsi_pkg::ST_STAT_D:
            begin
                cmd.cap_tail = 1'b1;
                state_next   = rqsi_pkg::ST_DONE;
            end
            rqsi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rqsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rqsi_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/ring_queue_with_sorted_insert.sv @@
// ring_queue_with_sorted_insert: top level, joins rqsi_ctrl and rqsi_dpath
// depends on rqsi_pkg, rqsi_ctrl, rqsi_dpath
//
// usage
// - input channel in_valid/in_ready carries one request beat: req_type and value
//   (status, enqueue at tail, priority enqueue, dequeue)
// - output channel out_valid/out_ready returns exactly one result beat per request
//   with accepted, out_value, head_value, tail_value, occupancy, is_empty,
//   is_full and free_slots, all after the request took effect
// - one request is worked on at a time; in_ready is high only while idle
// - each request passes the exec, status and done states; a dequeue adds a take
//   state, and a priority enqueue adds a walk over the stored entries that it
//   compares, at most 14 of them, and a place state; the slot memory has one
//   read and one write port and the walk moves one entry per cycle
// - the next request is taken the cycle after the result is loaded, so a new
//   request is not taken before the last one is through
// - the result sits in an output register, so the next request is taken while
//   an earlier result still waits; a stalled receiver holds the result steady
//   and a finished request then waits until that register is free
// - reset clears head and tail pointers (queue empty) and the handshake state;
//   slot contents are not cleared and empty-queue head/tail values read as zero
`default_nettype none

module ring_queue_with_sorted_insert (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [1:0]   req_type,
    input  wire [31:0]  value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        accepted,
    output logic [31:0] out_value,
    output logic [31:0] head_value,
    output logic [31:0] tail_value,
    output logic [3:0]  occupancy,
    output logic        is_empty,
    output logic        is_full,
    output logic [3:0]  free_slots
);

    rqsi_pkg::cmd_t cmd;
    rqsi_pkg::sts_t sts;

    rqsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rqsi_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts),
        .accepted   (accepted),
        .out_value  (out_value),
        .head_value (head_value),
        .tail_value (tail_value),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .free_slots (free_slots)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in progress");

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.full && sts.empty))
        else $error("queue flagged full and empty at once");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> head_value == '0 && tail_value == '0 && occupancy == '0)
        else $error("empty queue reports entries");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> out_value == '0)
        else $error("refused request reports a dequeued value");

endmodule

`default_nettype wire
